// ===== hw/rtl/lz4_block_decompressor_defines.svh =====
// Assertion macros shared by the LZ4 block decompressor checkers.
// No dependencies; included by files that assert.
`ifndef LZ4_BLOCK_DECOMPRESSOR_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LZ4BD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LZ4BD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lz4bd_pkg.sv =====
// Shared types, status codes and helpers for the LZ4 block decompressor.
// No dependencies.
package lz4bd_pkg;

  localparam int LEN_W            = 29;
  localparam int WINDOW_DEPTH_DEF = 65536;
  localparam int QUEUE_DEPTH      = 2;
  localparam int NIBBLE_MAX       = 15;
  localparam int EXT_MORE         = 255;
  localparam int MIN_MATCH        = 4;
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(268435456);

  // Result status codes
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_TRUNC  = 3'd2;
  localparam logic [2:0] ST_BADOFF = 3'd3;
  localparam logic [2:0] ST_OVER   = 3'd4;
  localparam logic [2:0] ST_REJECT = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_data;
    logic [2:0]       status;
    logic             copy_pending;
    logic [LEN_W-1:0] out_count;
  } result_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic             emit;
    logic             copy;
    logic [7:0]       lit_byte;
    logic [2:0]       status;
    logic             copy_pending;
    logic [LEN_W-1:0] out_count;
  } cmd_t;

  // Length add that saturates at the largest length
  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [8:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W-8){1'b0}}, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lz4bd_fifo.sv =====
// Small first-in first-out queue with registered occupancy.
// Depends on lz4bd_pkg for the default depth.
module lz4bd_fifo import lz4bd_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [IW-1:0]     wr_ptr;
  logic [IW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Store on transfer in
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/lz4bd_front.sv =====
// Front end: parses the compressed stream, tracks lengths, limits and errors,
// and hands one classified command per item to the back end.
// Depends on lz4bd_pkg.
module lz4bd_front import lz4bd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [LEN_W-1:0]             cfg_data,
  input  logic                         push,
  input  item_t                        item,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [$bits(cmd_t)+2*AW-1:0] q_data
);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LITERALS, PH_OFF_LO,
    PH_OFF_HI, PH_MATCHEXT, PH_COPY, PH_COPY_LAST
  } phase_t;

  phase_t                  phase, phase_next;
  logic [LEN_W-1:0]        literal_left, literal_left_next;
  logic [LEN_W-1:0]        match_left, match_left_next;
  logic [3:0]              match_nibble, match_nibble_next;
  logic [15:0]             match_distance, match_distance_next;
  logic [LEN_W-1:0]        produced, produced_next;
  logic [2:0]              final_status, final_status_next;
  logic [AW-1:0]           wptr, wptr_next;
  logic signed [LEN_W:0]   room, room_next;

  logic                    accept;
  logic                    last;
  logic [7:0]              b;
  logic                    copying;
  logic                    reject;
  logic                    emit;
  logic                    copy;
  logic [LEN_W-1:0]        lit_len;
  logic                    lit_over;
  logic [8:0]              mt_add;
  logic [LEN_W-1:0]        mt_len;
  logic                    mt_over;
  logic [15:0]             dist_full;
  logic                    bad_off;
  logic [AW:0]             rd_diff;
  logic [AW-1:0]           rd_ptr;
  cmd_t                    cmd;

  assign accept  = push && !q_full;
  assign q_push  = accept;
  assign b       = item.in_byte;
  assign last    = item.last_byte;
  assign copying = (phase == PH_COPY) || (phase == PH_COPY_LAST);
  assign reject  = (final_status != ST_RUN) || (item.mode != copying);

  // Length candidates and limit checks against remaining room
  assign lit_len   = (phase == PH_TOKEN) ? {{(LEN_W-4){1'b0}}, b[7:4]}
                                         : sat_add(literal_left, {1'b0, b});
  assign lit_over  = $signed({1'b0, lit_len}) > room;
  assign mt_add    = (b == 8'(EXT_MORE)) ? 9'(EXT_MORE) : {1'b0, b} + 9'(MIN_MATCH);
  assign mt_len    = (phase == PH_OFF_HI)
                     ? {{(LEN_W-4){1'b0}}, match_nibble} + LEN_W'(MIN_MATCH)
                     : sat_add(match_left, mt_add);
  assign mt_over   = $signed({1'b0, mt_len}) > room;
  assign dist_full = {b, match_distance[7:0]};
  assign bad_off   = (dist_full == 16'd0)
                     || ({{(LEN_W-16){1'b0}}, dist_full} > produced);

  // History read position, wrapped into the window
  assign rd_diff = {1'b0, wptr} - {{(AW-15){1'b0}}, match_distance};
  assign rd_ptr  = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(WINDOW_DEPTH)) : rd_diff[AW-1:0];

  // Step the parser for one item
  always_comb begin
    phase_next          = phase;
    literal_left_next   = literal_left;
    match_left_next     = match_left;
    match_nibble_next   = match_nibble;
    match_distance_next = match_distance;
    final_status_next   = final_status;
    emit                = 1'b0;
    copy                = 1'b0;
    if (!reject) begin
      case (phase)
        PH_TOKEN, PH_LITEXT: begin
          literal_left_next = lit_len;
          if (phase == PH_TOKEN) begin
            match_nibble_next = b[3:0];
          end
          if ((phase == PH_TOKEN && b[7:4] == 4'(NIBBLE_MAX))
              || (phase == PH_LITEXT && b == 8'(EXT_MORE))) begin
            if (last) final_status_next = ST_TRUNC;
            else      phase_next        = PH_LITEXT;
          end else if (lit_len == '0) begin
            if (last) final_status_next = ST_DONE;
            else      phase_next        = PH_OFF_LO;
          end else if (lit_over) begin
            final_status_next = ST_OVER;
          end else if (last) begin
            final_status_next = ST_TRUNC;
          end else begin
            phase_next = PH_LITERALS;
          end
        end
        PH_LITERALS: begin
          emit              = 1'b1;
          literal_left_next = literal_left - 1'b1;
          if (literal_left_next == '0) begin
            if (last) final_status_next = ST_DONE;
            else      phase_next        = PH_OFF_LO;
          end else if (last) begin
            final_status_next = ST_TRUNC;
          end
        end
        PH_OFF_LO: begin
          match_distance_next = {8'd0, b};
          if (last) final_status_next = ST_TRUNC;
          else      phase_next        = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          match_distance_next = dist_full;
          if (bad_off) begin
            final_status_next = ST_BADOFF;
          end else if (match_nibble == 4'(NIBBLE_MAX)) begin
            match_left_next = LEN_W'(NIBBLE_MAX);
            if (last) final_status_next = ST_TRUNC;
            else      phase_next        = PH_MATCHEXT;
          end else begin
            match_left_next = mt_len;
            if (mt_over) final_status_next = ST_OVER;
            else         phase_next        = last ? PH_COPY_LAST : PH_COPY;
          end
        end
        PH_MATCHEXT: begin
          match_left_next = mt_len;
          if (b == 8'(EXT_MORE)) begin
            if (last) final_status_next = ST_TRUNC;
          end else if (mt_over) begin
            final_status_next = ST_OVER;
          end else begin
            phase_next = last ? PH_COPY_LAST : PH_COPY;
          end
        end
        default: begin
          // copy tick in either copy phase
          emit            = 1'b1;
          copy            = 1'b1;
          match_left_next = match_left - 1'b1;
          if (match_left_next == '0) begin
            if (phase == PH_COPY_LAST) final_status_next = ST_DONE;
            else                       phase_next        = PH_TOKEN;
          end
        end
      endcase
    end
    produced_next = emit ? produced + 1'b1 : produced;
    room_next     = emit ? room - 1'b1 : room;
    wptr_next     = wptr;
    if (emit) begin
      wptr_next = (wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr + 1'b1;
    end
  end

  // Build the command for the back end
  always_comb begin
    cmd.emit         = emit;
    cmd.copy         = copy;
    cmd.lit_byte     = b;
    cmd.status       = reject ? ST_REJECT : final_status_next;
    cmd.copy_pending = (final_status_next == ST_RUN)
                       && (phase_next == PH_COPY || phase_next == PH_COPY_LAST);
    cmd.out_count    = produced_next;
  end

  assign q_data = {cmd, rd_ptr, wptr};

  // Hold parser state; advance on transfer, reload room on a limit write
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      literal_left   <= '0;
      match_left     <= '0;
      match_nibble   <= '0;
      match_distance <= '0;
      produced       <= '0;
      final_status   <= ST_RUN;
      wptr           <= '0;
      room           <= $signed({1'b0, LIMIT_RESET});
    end else begin
      if (cfg_write) begin
        room <= $signed({1'b0, cfg_data} - {1'b0, produced});
      end else if (accept) begin
        room <= room_next;
      end
      if (accept) begin
        phase          <= phase_next;
        literal_left   <= literal_left_next;
        match_left     <= match_left_next;
        match_nibble   <= match_nibble_next;
        match_distance <= match_distance_next;
        produced       <= produced_next;
        final_status   <= final_status_next;
        wptr           <= wptr_next;
      end
    end
  end

endmodule

// ===== hw/rtl/lz4bd_back.sv =====
// Back end: history window memory, match byte fetch with forwarding,
// and the result queue.
// Depends on lz4bd_pkg and lz4bd_fifo.
module lz4bd_back import lz4bd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic [$bits(cmd_t)+2*AW-1:0] q_data,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output result_t                      result
);

  localparam int RW = $bits(result_t);

  logic [7:0]    history [WINDOW_DEPTH];

  cmd_t          q_cmd;
  logic [AW-1:0] q_rd;
  logic [AW-1:0] q_wr;

  logic          s_valid;
  cmd_t          s_cmd;
  logic [AW-1:0] s_wr;
  logic          s_fwd;
  logic [7:0]    s_fwd_data;
  logic [7:0]    rd_q;

  logic          s_go;
  logic          take;
  logic          wr_en;
  logic [7:0]    data;
  logic          oq_full;
  result_t       res_in;
  logic [RW-1:0] res_vec;

  assign {q_cmd, q_rd, q_wr} = q_data;

  // Move the stage on when the result queue has room; refill behind it
  assign s_go  = s_valid && !oq_full;
  assign take  = !q_empty && (!s_valid || s_go);
  assign q_pop = take;
  assign wr_en = s_go && s_cmd.emit;
  assign data  = !s_cmd.copy ? s_cmd.lit_byte : (s_fwd ? s_fwd_data : rd_q);

  // History window: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      history[s_wr] <= data;
    end
    if (take) begin
      rd_q <= history[q_rd];
    end
  end

  // Fetch stage; forward the byte written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take) begin
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
    if (take) begin
      s_cmd      <= q_cmd;
      s_wr       <= q_wr;
      s_fwd      <= wr_en && (s_wr == q_rd);
      s_fwd_data <= data;
    end
  end

  always_comb begin
    res_in.out_valid    = s_cmd.emit;
    res_in.out_data     = s_cmd.emit ? data : 8'd0;
    res_in.status       = s_cmd.status;
    res_in.copy_pending = s_cmd.copy_pending;
    res_in.out_count    = s_cmd.out_count;
  end

  lz4bd_fifo #(
    .DATA_W (RW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s_go),
    .wdata (res_in),
    .full  (oq_full),
    .pop   (pop),
    .rdata (res_vec),
    .empty (empty)
  );

  assign result = result_t'(res_vec);

endmodule

// ===== hw/rtl/lz4_block_decompressor.sv =====
// LZ4 block decompressor: one compressed byte or copy tick per cycle while full is low, one result each.
// A result passes through the command queue, the fetch stage and the result queue, all registered, before it shows.
// Throughput: one item per cycle while the queues have room, set by the single history read and write per cycle.
// Reset (rst, synchronous): parser and queues cleared, limit reloaded to LIMIT_RESET; history window is not cleared,
// so no clearing pass is needed and items are taken the cycle after reset.
module lz4_block_decompressor import lz4bd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             push,
  input  item_t            item,
  output logic             full,
  input  logic             pop,
  output result_t          result,
  output logic             empty
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int QW = $bits(cmd_t) + 2 * AW;

  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_empty;

  lz4bd_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AW           (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .q_full    (full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Command queue between parser and history
  lz4bd_fifo #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lz4bd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AW           (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== hw/rtl/lz4bd_checker.sv =====
// Port-level checks for the LZ4 block decompressor, bound to the top level.
// Depends on lz4bd_pkg and lz4_block_decompressor_defines.svh.
`include "lz4_block_decompressor_defines.svh"

module lz4bd_checker import lz4bd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pop,
  input logic    empty,
  input result_t result
);

  // Emitted byte adds exactly one to the count
  `LZ4BD_ASSERT_NEXT(a_emit_count, pop && !empty, empty || !result.out_valid || result.out_count == $past(result.out_count) + 1'b1, "count did not advance by one on an emitted byte")

  // No byte, no change in count
  `LZ4BD_ASSERT_NEXT(a_idle_count, pop && !empty, empty || result.out_valid || result.out_count == $past(result.out_count), "count moved without an emitted byte")

  // Finished or failed block: the next result popped is a rejection
  `LZ4BD_ASSERT_NEXT(a_sticky_end, pop && !empty && result.status != ST_RUN && result.status != ST_REJECT, empty || result.status == ST_REJECT, "item accepted after the block ended")

  // Rejected item carries no byte
  `LZ4BD_ASSERT_NOW(a_reject_quiet, !empty && result.status == ST_REJECT, !result.out_valid && result.out_data == 8'd0 && !result.copy_pending || !result.out_valid && result.out_data == 8'd0, "rejected item produced data")

endmodule

bind lz4_block_decompressor lz4bd_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

// ===== verif/tb_lz4_block_decompressor.sv =====
// Self-checking testbench for the LZ4 block decompressor: random bursty stimulus,
// an in-bench decoder model and a result checker. Depends on lz4bd_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_lz4_block_decompressor;
  import lz4bd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Decoder phases of the bench model
  typedef enum logic [2:0] {
    S_TOKEN, S_LIT_EXT, S_LITERALS, S_DIST_LO, S_DIST_HI, S_MATCH_EXT, S_COPY, S_COPY_FINAL
  } dec_phase_t;

  // Ways the block can end
  typedef enum int {
    END_EMPTY_TOKEN, END_LAST_LITERAL, END_AFTER_COPY, TRUNC_TOKEN, TRUNC_LIT_EXT,
    TRUNC_LIT_LEN, TRUNC_LITERAL, TRUNC_DIST_LO, TRUNC_DIST_HI, TRUNC_MATCH_EXT,
    BAD_DIST_ZERO, BAD_DIST_FAR, OVER_LITERALS, OVER_MATCH
  } ending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             push = 1'b0;
  item_t            item = '0;
  logic             full;
  logic             pop = 1'b0;
  result_t          result;
  logic             empty;

  // Bench decoder state
  dec_phase_t       dec_phase = S_TOKEN;
  logic [LEN_W-1:0] lits_left = '0;
  logic [LEN_W-1:0] copy_left = '0;
  logic [3:0]       copy_nib = '0;
  logic [15:0]      copy_dist = '0;
  logic [LEN_W-1:0] bytes_out = '0;
  logic [2:0]       block_status = ST_RUN;
  logic [LEN_W-1:0] byte_limit = LIMIT_RESET;
  bit   [7:0]       out_window [0:65535];

  item_t   pending_items[$];
  result_t predicted_results[$];

  // Stimulus bookkeeping
  int unsigned gen_items = 0;
  int unsigned gen_bytes = 0;
  int unsigned gen_seqs = 0;

  // Run statistics
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_rejected = 0;
  int unsigned n_decoded = 0;
  int unsigned n_limit_writes = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycle = 0;
  int unsigned stall_kind = 0;
  ending_t     ending = END_EMPTY_TOKEN;

  lz4_block_decompressor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic logic [LEN_W-1:0] len_add(logic [LEN_W-1:0] a, int unsigned b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + (LEN_W+1)'(b);
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  function automatic logic over_limit(logic [LEN_W-1:0] len);
    return ({1'b0, bytes_out} + {1'b0, len}) > {1'b0, byte_limit};
  endfunction

  function automatic void literal_count_known(logic lastb);
    if (lits_left == 0) begin
      if (lastb) block_status = ST_DONE;
      else dec_phase = S_DIST_LO;
    end else if (over_limit(lits_left)) begin
      block_status = ST_OVER;
    end else if (lastb) begin
      block_status = ST_TRUNC;
    end else begin
      dec_phase = S_LITERALS;
    end
  endfunction

  function automatic void copy_count_known(logic lastb);
    if (over_limit(copy_left)) block_status = ST_OVER;
    else dec_phase = lastb ? S_COPY_FINAL : S_COPY;
  endfunction

  // Advance the model by one accepted item and return the result it owes
  function automatic result_t decode_item(item_t it);
    result_t          r;
    logic             copying;
    logic [7:0]       b;
    logic             lastb;
    logic [LEN_W-1:0] src;
    r = '0;
    b = it.in_byte;
    lastb = it.last_byte;
    copying = (dec_phase == S_COPY || dec_phase == S_COPY_FINAL);
    if (block_status != ST_RUN || ((it.mode == MODE_BYTE) == copying)) begin
      r.status = ST_REJECT;
    end else begin
      if (it.mode == MODE_BYTE) begin
        case (dec_phase)
          S_TOKEN: begin
            lits_left = LEN_W'(b[7:4]);
            copy_nib = b[3:0];
            if (b[7:4] == 4'hF) begin
              if (lastb) block_status = ST_TRUNC;
              else dec_phase = S_LIT_EXT;
            end else begin
              literal_count_known(lastb);
            end
          end
          S_LIT_EXT: begin
            lits_left = len_add(lits_left, b);
            if (b == 8'hFF) begin
              if (lastb) block_status = ST_TRUNC;
            end else begin
              literal_count_known(lastb);
            end
          end
          S_LITERALS: begin
            out_window[bytes_out[15:0]] = b;
            bytes_out = bytes_out + 1'b1;
            r.out_valid = 1'b1;
            r.out_data = b;
            lits_left = lits_left - 1'b1;
            if (lits_left == 0) begin
              if (lastb) block_status = ST_DONE;
              else dec_phase = S_DIST_LO;
            end else if (lastb) begin
              block_status = ST_TRUNC;
            end
          end
          S_DIST_LO: begin
            copy_dist = {8'h00, b};
            if (lastb) block_status = ST_TRUNC;
            else dec_phase = S_DIST_HI;
          end
          S_DIST_HI: begin
            copy_dist[15:8] = b;
            if (copy_dist == 0 || LEN_W'(copy_dist) > bytes_out) begin
              block_status = ST_BADOFF;
            end else if (copy_nib == 4'hF) begin
              copy_left = LEN_W'(15);
              if (lastb) block_status = ST_TRUNC;
              else dec_phase = S_MATCH_EXT;
            end else begin
              copy_left = LEN_W'(copy_nib) + LEN_W'(4);
              copy_count_known(lastb);
            end
          end
          S_MATCH_EXT: begin
            copy_left = len_add(copy_left, b);
            if (b == 8'hFF) begin
              if (lastb) block_status = ST_TRUNC;
            end else begin
              copy_left = len_add(copy_left, 4);
              copy_count_known(lastb);
            end
          end
          default: ;
        endcase
      end else begin
        // Copy one byte from history
        src = bytes_out - LEN_W'(copy_dist);
        r.out_data = out_window[src[15:0]];
        r.out_valid = 1'b1;
        out_window[bytes_out[15:0]] = r.out_data;
        bytes_out = bytes_out + 1'b1;
        copy_left = copy_left - 1'b1;
        if (copy_left == 0) begin
          if (dec_phase == S_COPY_FINAL) block_status = ST_DONE;
          else dec_phase = S_TOKEN;
        end
      end
      r.status = block_status;
    end
    r.copy_pending = (block_status == ST_RUN) &&
                     (dec_phase == S_COPY || dec_phase == S_COPY_FINAL);
    r.out_count = bytes_out;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             $time, n_checked, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result with nothing predicted", got, 0);
      return;
    end
    want = predicted_results.pop_front();
    n_checked++;
    if (want.status == ST_REJECT) n_rejected++;
    if (want.out_valid) n_decoded++;
    if (got.out_valid !== want.out_valid)
      report_mismatch("out_valid", got.out_valid, want.out_valid);
    if (got.out_data !== want.out_data)
      report_mismatch("out_data", got.out_data, want.out_data);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.copy_pending !== want.copy_pending)
      report_mismatch("copy_pending", got.copy_pending, want.copy_pending);
    if (got.out_count !== want.out_count)
      report_mismatch("out_count", got.out_count, want.out_count);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps, fed from pending_items
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predicted_results.push_back(decode_item(item));
        n_items++;
      end
      // Offer the next item only once the current one has transferred
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          push <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each popped result; stall on a changing pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      stall_cycle++;
      if (stall_cycle % 50 == 0) stall_kind = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && n_items >= 500) begin
        // Long hold-off so the block backs up and raises full
        hold_done = 1'b1;
        hold_left = 80;
        pop <= 1'b0;
      end else begin
        case (stall_kind)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          default: pop <= (stall_cycle % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still predicted",
               cycles, predicted_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic mode, logic [7:0] b, logic lastb);
    item_t it;
    it.mode = mode;
    it.in_byte = b;
    it.last_byte = lastb;
    pending_items.push_back(it);
    gen_items++;
  endtask

  // Occasionally slip in an item the block must reject
  task automatic maybe_noise(bit in_copy);
    if ($urandom_range(0, 24) == 0)
      queue_item(in_copy ? MODE_BYTE : MODE_TICK, 8'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] literal_value();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic int unsigned pick_dist(int unsigned avail);
    if (avail > 65535) avail = 65535;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, (avail < 4) ? avail : 4);
    return $urandom_range(1, avail);
  endfunction

  task automatic queue_len_ext(int unsigned ext, logic lastb);
    while (ext >= 255) begin
      queue_item(MODE_BYTE, 8'hFF, 1'b0);
      ext -= 255;
    end
    queue_item(MODE_BYTE, ext[7:0], lastb);
  endtask

  task automatic queue_token_and_ext(int unsigned n, logic [3:0] mnib, logic lastb);
    if (n < 15) begin
      queue_item(MODE_BYTE, {n[3:0], mnib}, lastb);
    end else begin
      queue_item(MODE_BYTE, {4'hF, mnib}, 1'b0);
      queue_len_ext(n - 15, lastb);
    end
  endtask

  task automatic queue_literal_run(int unsigned n, logic [3:0] mnib);
    maybe_noise(1'b0);
    queue_token_and_ext(n, mnib, 1'b0);
    repeat (n) begin
      queue_item(MODE_BYTE, literal_value(), 1'b0);
      maybe_noise(1'b0);
    end
  endtask

  task automatic queue_ticks(int unsigned m);
    repeat (m) begin
      maybe_noise(1'b1);
      queue_item(MODE_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // One sequence; last_hdr marks the final byte of the match header
  task automatic queue_sequence(int unsigned n, int unsigned m, int unsigned match_dist,
                                bit with_ticks, bit last_hdr);
    logic [3:0] mnib;
    mnib = (m - 4 >= 15) ? 4'hF : 4'(m - 4);
    queue_literal_run(n, mnib);
    queue_item(MODE_BYTE, match_dist[7:0], 1'b0);
    queue_item(MODE_BYTE, match_dist[15:8], last_hdr && mnib != 4'hF);
    if (mnib == 4'hF) queue_len_ext(m - 19, last_hdr);
    if (with_ticks) queue_ticks(m);
    gen_bytes += n + m;
    gen_seqs++;
  endtask

  task automatic queue_random(int unsigned target);
    int unsigned n;
    int unsigned m;
    while (gen_items < target) begin
      if (gen_seqs == 12) n = 15 + 255 + $urandom_range(0, 8);
      else case ($urandom_range(0, 9))
        0: n = 0;
        7, 8: n = 15 + $urandom_range(0, 40);
        9: n = $urandom_range(1, 3);
        default: n = $urandom_range(1, 14);
      endcase
      if (gen_bytes == 0 && n == 0) n = 1;
      if (gen_seqs == 25) m = 19 + 255 + $urandom_range(0, 8);
      else if ($urandom_range(0, 4) == 0) m = 19 + $urandom_range(0, 40);
      else m = $urandom_range(4, 18);
      queue_sequence(n, m, pick_dist(gen_bytes + n), 1'b1, 1'b0);
    end
  endtask

  // Wait until every item has transferred and every result has been checked
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || predicted_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    byte_limit = value;
    n_limit_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned n;
    int unsigned m;
    int unsigned k;
    int unsigned match_dist;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero limit with only stray copy ticks, all rejected
    write_limit('0);
    repeat (4) queue_item(MODE_TICK, 8'($urandom), 1'($urandom));
    wait_drained();
    write_limit(LIMIT_RESET);

    // Directed: single literal with overlapping copy, stray items of both kinds,
    // a sequence without literals
    queue_item(MODE_TICK, 8'hFF, 1'b1);
    queue_sequence(1, 4, 1, 1'b1, 1'b0);
    queue_sequence(3, 5, 3, 1'b0, 1'b0);
    queue_item(MODE_BYTE, 8'h00, 1'b1);
    queue_ticks(5);
    queue_sequence(0, 4, 2, 1'b1, 1'b0);

    queue_random(900);
    wait_drained();

    // Drop the limit to zero after a match length was accepted; the copy goes on
    n = $urandom_range(1, 14);
    m = $urandom_range(4, 40);
    queue_sequence(n, m, pick_dist(gen_bytes + n), 1'b0, 1'b0);
    wait_drained();
    write_limit('0);
    queue_ticks(m);
    wait_drained();
    write_limit(LEN_W'($urandom_range(gen_bytes + 4096, int'(LIMIT_RESET) - 1)));

    queue_random(1700);

    // Close the block one of several ways
    ending = ending_t'($urandom_range(0, 13));
    n = $urandom_range(2, 12);
    case (ending)
      END_EMPTY_TOKEN: queue_item(MODE_BYTE, {4'h0, 4'($urandom)}, 1'b1);
      END_LAST_LITERAL, TRUNC_LITERAL: begin
        k = (ending == END_LAST_LITERAL) ? n - 1 : $urandom_range(0, n - 2);
        queue_token_and_ext(n, 4'($urandom), 1'b0);
        for (int i = 0; i < n; i++) queue_item(MODE_BYTE, literal_value(), i == k);
      end
      END_AFTER_COPY: begin
        m = ($urandom_range(0, 1) != 0) ? $urandom_range(4, 18) : $urandom_range(19, 60);
        queue_sequence(n, m, pick_dist(gen_bytes + n), 1'b1, 1'b1);
      end
      TRUNC_TOKEN: queue_item(MODE_BYTE, {4'hF, 4'($urandom)}, 1'b1);
      TRUNC_LIT_EXT: begin
        queue_item(MODE_BYTE, {4'hF, 4'($urandom)}, 1'b0);
        queue_item(MODE_BYTE, 8'hFF, 1'b1);
      end
      TRUNC_LIT_LEN: queue_token_and_ext($urandom_range(1, 40), 4'($urandom), 1'b1);
      TRUNC_DIST_LO: begin
        queue_literal_run(n, 4'($urandom));
        queue_item(MODE_BYTE, 8'($urandom), 1'b1);
      end
      TRUNC_DIST_HI, TRUNC_MATCH_EXT: begin
        match_dist = pick_dist(gen_bytes + n);
        queue_literal_run(n, 4'hF);
        queue_item(MODE_BYTE, match_dist[7:0], 1'b0);
        queue_item(MODE_BYTE, match_dist[15:8], ending == TRUNC_DIST_HI);
        if (ending == TRUNC_MATCH_EXT) queue_item(MODE_BYTE, 8'hFF, 1'b1);
      end
      BAD_DIST_ZERO, BAD_DIST_FAR: begin
        match_dist = (ending == BAD_DIST_ZERO) ? 0 : gen_bytes + n + $urandom_range(1, 100);
        queue_literal_run(n, 4'($urandom));
        queue_item(MODE_BYTE, match_dist[7:0], 1'b0);
        queue_item(MODE_BYTE, match_dist[15:8], 1'($urandom));
      end
      OVER_LITERALS: begin
        wait_drained();
        k = $urandom_range(0, 20);
        write_limit(LEN_W'(gen_bytes + k));
        queue_token_and_ext(k + 1 + $urandom_range(0, 20), 4'($urandom), 1'($urandom));
      end
      default: begin
        // Match longer than the room left under the limit
        wait_drained();
        n = $urandom_range(0, 5);
        k = $urandom_range(0, 3);
        write_limit(LEN_W'(gen_bytes + n + k));
        queue_sequence(n, $urandom_range(4 + k, 30), pick_dist(gen_bytes + n),
                       1'b0, 1'($urandom));
      end
    endcase
    // Everything after the end is rejected
    repeat (8) queue_item(1'($urandom), 8'($urandom), 1'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d transfers in, %0d results checked, %0d bytes decoded, %0d rejected",
             n_items, n_checked, n_decoded, n_rejected);
    $display("%0d limit writes; block closed by %s with status %0d, %0d mismatches",
             n_limit_writes, ending.name(), block_status, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
